// ===== sv/imtsc_pkg.sv =====
// Shared constants and types for the IMU tilt and stillness core.
// Holds the CORDIC angle table, the register map and the reset values.
// No dependencies.
package imtsc_pkg;

   localparam int SAMPLE_BITS_DEF = 16;

   // CORDIC angle path
   localparam int CORDIC_STEPS = 20;
   localparam int ANGLE_W      = 26;
   localparam int DEG90_Q16    = 5898240;
   localparam int ATAN_DEG_Q16 [CORDIC_STEPS] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
   };

   // result angle formats, degrees with 7 fraction bits
   localparam int PITCH_W   = 15;
   localparam int ROLL_W    = 16;
   localparam int PITCH_LIM = 11520;
   localparam int ROLL_LIM  = 23040;

   // register port
   localparam int CSR_W       = 16;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GYRO_BIAS_X,
      CSR_GYRO_BIAS_Y,
      CSR_GYRO_BIAS_Z,
      CSR_STILL_ACCEL_LOW,
      CSR_STILL_ACCEL_HIGH,
      CSR_STILL_GYRO_LIMIT
   } csr_index_type;

   localparam logic [CSR_W-1:0] STILL_ACCEL_LOW_RST  = 16'd3482;
   localparam logic [CSR_W-1:0] STILL_ACCEL_HIGH_RST = 16'd4710;
   localparam logic [CSR_W-1:0] STILL_GYRO_LIMIT_RST = 16'd32;

endpackage

// ===== sv/imtsc_cordic.sv =====
// Pipelined vectoring CORDIC: atan2(y, x) in degrees with 7 fraction bits.
// One quadrant pre-rotation stage, one stage per CORDIC step, one rounding stage.
// Depends on imtsc_pkg.
module imtsc_cordic import imtsc_pkg::*; #(
   parameter int IN_W  = 25,
   parameter int OUT_W = ROLL_W,
   parameter int LIMIT = ROLL_LIM
) (
   input  logic                    clock,
   input  logic signed [IN_W-1:0]  x_in,
   input  logic signed [IN_W-1:0]  y_in,
   output logic signed [OUT_W-1:0] angle
);

   localparam int W  = IN_W + 19;
   localparam int QW = ANGLE_W - 9;

   logic signed [W-1:0]       x_ff    [0:CORDIC_STEPS];
   logic signed [W-1:0]       y_ff    [0:CORDIC_STEPS];
   logic signed [ANGLE_W-1:0] z_ff    [0:CORDIC_STEPS];
   logic                      zero_ff [0:CORDIC_STEPS];

   logic signed [W-1:0]       xs_in, ys_in, x0_in, y0_in;
   logic signed [ANGLE_W-1:0] z0_in;

   // scale by 2^16 and fold the left half plane onto the right
   always_comb begin
      xs_in = {{(W-IN_W-16){x_in[IN_W-1]}}, x_in, 16'b0};
      ys_in = {{(W-IN_W-16){y_in[IN_W-1]}}, y_in, 16'b0};
      x0_in = xs_in;
      y0_in = ys_in;
      z0_in = '0;
      if (xs_in[W-1]) begin
         if (!ys_in[W-1]) begin
            x0_in = ys_in;
            y0_in = -xs_in;
            z0_in = ANGLE_W'(DEG90_Q16);
         end else begin
            x0_in = -ys_in;
            y0_in = xs_in;
            z0_in = -ANGLE_W'(DEG90_Q16);
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]    <= x0_in;
      y_ff[0]    <= y0_in;
      z_ff[0]    <= z0_in;
      zero_ff[0] <= (x_in == '0) && (y_in == '0);
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [W-1:0] xsh, ysh;
      assign xsh = x_ff[i] >>> i;
      assign ysh = y_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (!y_ff[i][W-1]) begin
            x_ff[i+1] <= x_ff[i] + ysh;
            y_ff[i+1] <= y_ff[i] - xsh;
            z_ff[i+1] <= z_ff[i] + ANGLE_W'(ATAN_DEG_Q16[i]);
         end else begin
            x_ff[i+1] <= x_ff[i] - ysh;
            y_ff[i+1] <= y_ff[i] + xsh;
            z_ff[i+1] <= z_ff[i] - ANGLE_W'(ATAN_DEG_Q16[i]);
         end
         zero_ff[i+1] <= zero_ff[i];
      end
   end

   // round to 7 fraction bits and clamp
   logic signed [ANGLE_W-1:0] zr;
   logic signed [QW-1:0]      q;
   logic signed [OUT_W-1:0]   angle_in, angle_ff;

   always_comb begin
      zr = z_ff[CORDIC_STEPS] + ANGLE_W'(256);
      q  = zr[ANGLE_W-1:9];
      if (zero_ff[CORDIC_STEPS]) begin
         angle_in = '0;
      end else if (q > QW'(LIMIT)) begin
         angle_in = OUT_W'(LIMIT);
      end else if (q < -QW'(LIMIT)) begin
         angle_in = -OUT_W'(LIMIT);
      end else begin
         angle_in = q[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      angle_ff <= angle_in;
   end

   assign angle = angle_ff;

endmodule

// ===== sv/imu_tilt_and_stillness_core.sv =====
// From start to rsp_valid an item passes the bias, square and sum stages, the square-root
// pipeline (one root bit per stage) and the CORDIC stages.
// Throughput: one item per cycle; busy stays low and results are never held.
// Reset (synchronous) clears all valid bits and loads the register defaults.
// Depends on imtsc_pkg and imtsc_cordic.
module imu_tilt_and_stillness_core import imtsc_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_z,
   input  logic signed [SAMPLE_BITS-1:0] req_gyro_x,
   input  logic signed [SAMPLE_BITS-1:0] req_gyro_y,
   input  logic signed [SAMPLE_BITS-1:0] req_gyro_z,
   input  logic                         csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_W-1:0]             csr_wr_data,
   output logic                         rsp_valid,
   output logic signed [15:0]           rsp_rate_x,
   output logic signed [15:0]           rsp_rate_y,
   output logic signed [15:0]           rsp_rate_z,
   output logic [15:0]                  rsp_accel_magnitude,
   output logic [15:0]                  rsp_rate_magnitude,
   output logic signed [PITCH_W-1:0]    rsp_pitch_deg,
   output logic signed [ROLL_W-1:0]     rsp_roll_deg,
   output logic                         rsp_is_still
);

   localparam int SB     = SAMPLE_BITS;
   localparam int DW     = ((SB > 16) ? SB : 16) + 1;
   localparam int SQ_N   = SB + 8;
   localparam int RAD_W  = 2 * SQ_N;
   localparam int CIN_W  = SB + 9;
   localparam int CMP_W  = ((2 * SB > 32) ? 2 * SB : 32);
   localparam int LAT    = 25 + SQ_N;
   localparam int D_AX   = 2 + SQ_N;
   localparam int D_RATE = LAT - 1;
   localparam int D_STL  = LAT - 4;
   localparam int D_MAG  = LAT - 3 - SQ_N;

   // every start is taken
   assign busy = 1'b0;

   // ---------------- configuration registers ----------------
   logic signed [15:0] bias_ff [3];
   logic [15:0]        acc_low_ff, acc_high_ff, gyro_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff[0]  <= '0;
         bias_ff[1]  <= '0;
         bias_ff[2]  <= '0;
         acc_low_ff  <= STILL_ACCEL_LOW_RST;
         acc_high_ff <= STILL_ACCEL_HIGH_RST;
         gyro_lim_ff <= STILL_GYRO_LIMIT_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_GYRO_BIAS_X:      bias_ff[0]  <= csr_wr_data;
            CSR_GYRO_BIAS_Y:      bias_ff[1]  <= csr_wr_data;
            CSR_GYRO_BIAS_Z:      bias_ff[2]  <= csr_wr_data;
            CSR_STILL_ACCEL_LOW:  acc_low_ff  <= csr_wr_data;
            CSR_STILL_ACCEL_HIGH: acc_high_ff <= csr_wr_data;
            CSR_STILL_GYRO_LIMIT: gyro_lim_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // ---------------- valid line ----------------
   logic [LAT-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[LAT-2:0], start && !busy};
      end
   end

   // ---------------- stage 1: bias removal ----------------
   logic signed [SB-1:0] g_in    [3];
   logic signed [DW-1:0] diff    [3];
   logic signed [15:0]   rate_in [3];

   assign g_in[0] = req_gyro_x;
   assign g_in[1] = req_gyro_y;
   assign g_in[2] = req_gyro_z;

   // subtract bias and saturate to 16 bits
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff[k] = DW'(g_in[k]) - DW'(bias_ff[k]);
         if (diff[k] > DW'(32767)) begin
            rate_in[k] = 16'sh7fff;
         end else if (diff[k] < -DW'(32768)) begin
            rate_in[k] = -16'sh8000;
         end else begin
            rate_in[k] = diff[k][15:0];
         end
      end
   end

   logic signed [SB-1:0] ax1_ff, ay1_ff, az1_ff;
   logic signed [15:0]   rate1_ff [3];

   always_ff @(posedge clock) begin
      ax1_ff <= req_accel_x;
      ay1_ff <= req_accel_y;
      az1_ff <= req_accel_z;
      for (int k = 0; k < 3; k++) begin
         rate1_ff[k] <= rate_in[k];
      end
   end

   // ---------------- stage 2: squares ----------------
   logic signed [2*SB-1:0] axsq2_ff, aysq2_ff, azsq2_ff;
   logic signed [31:0]     rsq2_ff [3];
   logic [31:0]            lo2_ff, hi2_ff, lim2_ff;

   always_ff @(posedge clock) begin
      axsq2_ff <= ax1_ff * ax1_ff;
      aysq2_ff <= ay1_ff * ay1_ff;
      azsq2_ff <= az1_ff * az1_ff;
      for (int k = 0; k < 3; k++) begin
         rsq2_ff[k] <= rate1_ff[k] * rate1_ff[k];
      end
      lo2_ff  <= acc_low_ff * acc_low_ff;
      hi2_ff  <= acc_high_ff * acc_high_ff;
      lim2_ff <= gyro_lim_ff * gyro_lim_ff;
   end

   // ---------------- stage 3: sums ----------------
   logic [2*SB-1:0] sxz3_ff, asum3_ff;
   logic [31:0]     gsum3_ff;

   always_ff @(posedge clock) begin
      sxz3_ff  <= unsigned'(axsq2_ff) + unsigned'(azsq2_ff);
      asum3_ff <= unsigned'(axsq2_ff) + unsigned'(azsq2_ff) + unsigned'(aysq2_ff);
      gsum3_ff <= unsigned'(rsq2_ff[0]) + unsigned'(rsq2_ff[1]) + unsigned'(rsq2_ff[2]);
   end

   // ---------------- stage 4: stillness compare ----------------
   logic still4_ff;

   always_ff @(posedge clock) begin
      still4_ff <= (CMP_W'(asum3_ff) > CMP_W'(lo2_ff)) &&
                   (CMP_W'(asum3_ff) < CMP_W'(hi2_ff)) &&
                   (CMP_W'(gsum3_ff) < CMP_W'(lim2_ff));
   end

   // ---------------- square roots, one root bit per stage ----------------
   // lane 0: accel length, lane 1: rate length, lane 2: pitch denominator
   logic [RAD_W-1:0] sq_rad0 [3];

   assign sq_rad0[0] = RAD_W'(asum3_ff);
   assign sq_rad0[1] = RAD_W'(gsum3_ff);
   assign sq_rad0[2] = {sxz3_ff, 16'b0};

   logic [RAD_W-1:0]  sq_rad_ff  [3][SQ_N];
   logic [SQ_N+1:0]   sq_rem_ff  [3][SQ_N];
   logic [SQ_N-1:0]   sq_root_ff [3][SQ_N];

   for (genvar l = 0; l < 3; l++) begin : g_lane
      for (genvar k = 0; k < SQ_N; k++) begin : g_bit
         logic [RAD_W-1:0] rad_src;
         logic [SQ_N+1:0]  rem_src, rem_try, trial;
         logic [SQ_N-1:0]  root_src;
         logic             ge;

         if (k == 0) begin : g_first
            assign rad_src  = sq_rad0[l];
            assign rem_src  = '0;
            assign root_src = '0;
         end else begin : g_next
            assign rad_src  = sq_rad_ff[l][k-1];
            assign rem_src  = sq_rem_ff[l][k-1];
            assign root_src = sq_root_ff[l][k-1];
         end

         // bring down two radicand bits and try the next root bit
         assign rem_try = {rem_src[SQ_N-1:0], rad_src[RAD_W-1 -: 2]};
         assign trial   = {root_src, 2'b01};
         assign ge      = (rem_try >= trial);

         always_ff @(posedge clock) begin
            sq_rad_ff[l][k]  <= {rad_src[RAD_W-3:0], 2'b00};
            sq_rem_ff[l][k]  <= ge ? (rem_try - trial) : rem_try;
            sq_root_ff[l][k] <= {root_src[SQ_N-2:0], ge};
         end
      end
   end

   logic [SQ_N-1:0] amag_root, gmag_root, den_root;
   logic [15:0]     amag_sat, gmag_sat;

   assign amag_root = sq_root_ff[0][SQ_N-1];
   assign gmag_root = sq_root_ff[1][SQ_N-1];
   assign den_root  = sq_root_ff[2][SQ_N-1];

   // saturate lengths to 16 bits
   assign amag_sat = (|amag_root[SQ_N-1:16]) ? 16'hffff : amag_root[15:0];
   assign gmag_sat = (|gmag_root[SQ_N-1:16]) ? 16'hffff : gmag_root[15:0];

   // ---------------- alignment delay lines ----------------
   logic signed [SB-1:0] ax_dly_ff   [D_AX];
   logic signed [SB-1:0] ay_dly_ff   [D_AX];
   logic signed [SB-1:0] az_dly_ff   [D_AX];
   logic signed [15:0]   rate_dly_ff [3][D_RATE];
   logic                 stl_dly_ff  [D_STL];
   logic [15:0]          amag_dly_ff [D_MAG];
   logic [15:0]          gmag_dly_ff [D_MAG];

   // advance every delay line by one tap
   always_ff @(posedge clock) begin
      ax_dly_ff[0] <= ax1_ff;
      ay_dly_ff[0] <= ay1_ff;
      az_dly_ff[0] <= az1_ff;
      for (int j = 1; j < D_AX; j++) begin
         ax_dly_ff[j] <= ax_dly_ff[j-1];
         ay_dly_ff[j] <= ay_dly_ff[j-1];
         az_dly_ff[j] <= az_dly_ff[j-1];
      end
      for (int k = 0; k < 3; k++) begin
         rate_dly_ff[k][0] <= rate1_ff[k];
         for (int j = 1; j < D_RATE; j++) begin
            rate_dly_ff[k][j] <= rate_dly_ff[k][j-1];
         end
      end
      stl_dly_ff[0] <= still4_ff;
      for (int j = 1; j < D_STL; j++) begin
         stl_dly_ff[j] <= stl_dly_ff[j-1];
      end
      amag_dly_ff[0] <= amag_sat;
      gmag_dly_ff[0] <= gmag_sat;
      for (int j = 1; j < D_MAG; j++) begin
         amag_dly_ff[j] <= amag_dly_ff[j-1];
         gmag_dly_ff[j] <= gmag_dly_ff[j-1];
      end
   end

   // ---------------- angles ----------------
   logic signed [CIN_W-1:0] roll_x, roll_y, pitch_x, pitch_y;

   assign roll_x  = CIN_W'(az_dly_ff[D_AX-1]);
   assign roll_y  = -CIN_W'(ax_dly_ff[D_AX-1]);
   assign pitch_x = {1'b0, den_root};
   assign pitch_y = CIN_W'(ay_dly_ff[D_AX-1]) <<< 8;

   imtsc_cordic #(
      .IN_W  (CIN_W),
      .OUT_W (ROLL_W),
      .LIMIT (ROLL_LIM)
   ) u_roll (
      .clock (clock),
      .x_in  (roll_x),
      .y_in  (roll_y),
      .angle (rsp_roll_deg)
   );

   imtsc_cordic #(
      .IN_W  (CIN_W),
      .OUT_W (PITCH_W),
      .LIMIT (PITCH_LIM)
   ) u_pitch (
      .clock (clock),
      .x_in  (pitch_x),
      .y_in  (pitch_y),
      .angle (rsp_pitch_deg)
   );

   // ---------------- result ----------------
   assign rsp_valid           = valid_ff[LAT-1];
   assign rsp_rate_x          = rate_dly_ff[0][D_RATE-1];
   assign rsp_rate_y          = rate_dly_ff[1][D_RATE-1];
   assign rsp_rate_z          = rate_dly_ff[2][D_RATE-1];
   assign rsp_accel_magnitude = amag_dly_ff[D_MAG-1];
   assign rsp_rate_magnitude  = gmag_dly_ff[D_MAG-1];
   assign rsp_is_still        = stl_dly_ff[D_STL-1];

`ifndef SYNTH
   // a still item has its lengths inside the thresholds
   a_still_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_still |->
         (rsp_accel_magnitude >= acc_low_ff) && (rsp_accel_magnitude < acc_high_ff) &&
         (rsp_rate_magnitude < gyro_lim_ff))
      else $error("stillness flag disagrees with magnitudes");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_deg <= 16'sd23040) && (rsp_roll_deg >= -16'sd23040))
      else $error("roll outside clamp range");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_deg <= 15'sd11520) && (rsp_pitch_deg >= -15'sd11520))
      else $error("pitch outside clamp range");
`endif

endmodule
